// ----- rtl/lpvt_pkg.sv -----
// Package for the length-prefixed to varint transcoder.
// Holds shared widths, types, register indexes and header codes.
// No dependencies.
package lpvt_pkg;

    localparam int CFG_IDX_W = 2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [6:0]           class_t;
    typedef logic [7:0]           byte_t;
    typedef logic [6:0]           count_t;

    // Configuration register indexes
    localparam cfg_idx_t CFG_DELIMITER = 2'd0;
    localparam cfg_idx_t CFG_SKIP      = 2'd1;
    localparam cfg_idx_t CFG_FLEX      = 2'd2;

    // Header byte codes
    localparam byte_t HDR_DELIMITER = 8'd0;
    localparam byte_t HDR_LEN_MIN   = 8'd1;
    localparam byte_t HDR_LEN_MAX   = 8'd127;
    localparam byte_t HDR_SKIP      = 8'd128;
    localparam byte_t HDR_FLEX      = 8'd129;

    // Saturation limit of the class byte position
    localparam count_t POS_MAX = 7'd127;

    // Flags carried with each emitted class
    typedef struct packed {
        logic pattern_end;
        logic oversize;
    } emit_flags_t;

endpackage

// ----- rtl/lpvt_channels.sv -----
// Valid/ready channel interfaces of the transcoder: input bytes,
// output varint bytes and configuration writes.
// Depends on lpvt_pkg.
interface lpvt_byte_if
    import lpvt_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface lpvt_varint_if
    import lpvt_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t out_byte;
    logic  last;
    logic  pattern_end;
    logic  oversize;

    modport source (output valid, output out_byte, output last, output pattern_end,
                    output oversize, input ready);
    modport sink   (input valid, input out_byte, input last, input pattern_end,
                    input oversize, output ready);
endinterface

interface lpvt_cfg_if
    import lpvt_pkg::*;
();
    logic     valid;
    logic     ready;
    cfg_idx_t index;
    class_t   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/length_prefixed_to_varint_transcoder.sv -----
// Top level of the length-prefixed to varint transcoder.
// Depends on lpvt_pkg and the channel interfaces in lpvt_channels.sv.
//
// byte_in   : one old-format byte per transfer. In header position 0 emits
//             the delimiter class, 1..127 announce that many little-endian
//             class bytes, 128 emits the skip class, 129 the flex class,
//             130..255 are dropped.
// varint_out: LEB128 bytes, low 7-bit group first; last marks the final byte
//             of one input's result, pattern_end the delimiter, oversize a
//             class that lost nonzero high bytes.
// cfg       : writes the three class registers; always ready. Indexes beyond
//             the list are taken and ignored. Write only when idle.
// Timing: a byte that causes no output only updates the parser. A marker or a byte
//   that completes a class loads the 7-bit group shifter, which passes one group per
//   cycle to the output register while that register is free: the first byte passes
//   the shifter and then the output register. A class of n groups (up to
//   ceil(CLASS_BITS/7)) holds byte_in off until its last group has left the
//   shifter, and a stalled receiver holds the output register and the shifter.
// Reset: header position, empty accumulator, no output pending, class
//   registers at delimiter 0, skip 3, flex 4.
module length_prefixed_to_varint_transcoder
    import lpvt_pkg::*;
#(
    parameter int CLASS_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    lpvt_byte_if.sink     byte_in,
    lpvt_varint_if.source varint_out,
    lpvt_cfg_if.sink      cfg
);

    localparam int KEEP_BYTES = CLASS_BITS / 8;

    // Configuration registers
    class_t delim_class_reg;
    class_t skip_class_reg;
    class_t flex_class_reg;

    // Parser state
    count_t                bytes_left_reg, bytes_left_next;
    count_t                pos_reg, pos_next;
    logic [CLASS_BITS-1:0] acc_reg, acc_next;
    logic                  ovf_reg, ovf_next;

    // Group shifter
    logic                  emit_active_reg, emit_active_next;
    logic [CLASS_BITS-1:0] emit_val_reg, emit_val_next;
    emit_flags_t           emit_flags_reg, emit_flags_next;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    byte_t                 out_byte_reg, out_byte_next;
    logic                  out_last_reg, out_last_next;
    emit_flags_t           out_flags_reg, out_flags_next;

    logic                  in_fire;
    logic                  out_free;
    logic [CLASS_BITS-1:0] acc_upd;
    logic                  lane_hit;
    logic [CLASS_BITS-1:0] rest;
    logic                  more;

    assign byte_in.ready          = !emit_active_reg;
    assign cfg.ready              = 1'b1;
    assign varint_out.valid       = out_valid_reg;
    assign varint_out.out_byte    = out_byte_reg;
    assign varint_out.last        = out_last_reg;
    assign varint_out.pattern_end = out_flags_reg.pattern_end;
    assign varint_out.oversize    = out_flags_reg.oversize;

    assign in_fire  = byte_in.valid && !emit_active_reg;
    assign out_free = !out_valid_reg || varint_out.ready;
    assign rest     = emit_val_reg >> 7;
    assign more     = |rest;

    // Merge the incoming class byte into its lane
    always_comb
    begin
        acc_upd  = acc_reg;
        lane_hit = 1'b0;
        for (int i = 0; i < KEEP_BYTES; i++)
        begin
            if (pos_reg == 7'(i))
            begin
                acc_upd[i*8 +: 8] = acc_reg[i*8 +: 8] | byte_in.in_byte;
                lane_hit          = 1'b1;
            end
        end
    end

    // Next state of parser, shifter and output register
    always_comb
    begin
        bytes_left_next  = bytes_left_reg;
        pos_next         = pos_reg;
        acc_next         = acc_reg;
        ovf_next         = ovf_reg;
        emit_active_next = emit_active_reg;
        emit_val_next    = emit_val_reg;
        emit_flags_next  = emit_flags_reg;
        out_valid_next   = out_valid_reg;
        out_byte_next    = out_byte_reg;
        out_last_next    = out_last_reg;
        out_flags_next   = out_flags_reg;

        // Advance the shifter by one 7-bit group, or drop a taken byte
        if (emit_active_reg && out_free)
        begin
            out_valid_next   = 1'b1;
            out_byte_next    = {more, emit_val_reg[6:0]};
            out_last_next    = !more;
            out_flags_next   = emit_flags_reg;
            emit_val_next    = rest;
            emit_active_next = more;
        end
        else if (out_valid_reg && varint_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        // Parse the transferred byte
        if (in_fire)
        begin
            if (bytes_left_reg == '0)
            begin
                case (byte_in.in_byte) inside
                    HDR_DELIMITER:
                    begin
                        emit_active_next = 1'b1;
                        emit_val_next    = CLASS_BITS'(delim_class_reg);
                        emit_flags_next  = '{pattern_end: 1'b1, oversize: 1'b0};
                    end
                    [HDR_LEN_MIN:HDR_LEN_MAX]:
                    begin
                        bytes_left_next = byte_in.in_byte[6:0];
                        pos_next        = '0;
                        acc_next        = '0;
                        ovf_next        = 1'b0;
                    end
                    HDR_SKIP:
                    begin
                        emit_active_next = 1'b1;
                        emit_val_next    = CLASS_BITS'(skip_class_reg);
                        emit_flags_next  = '{pattern_end: 1'b0, oversize: 1'b0};
                    end
                    HDR_FLEX:
                    begin
                        emit_active_next = 1'b1;
                        emit_val_next    = CLASS_BITS'(flex_class_reg);
                        emit_flags_next  = '{pattern_end: 1'b0, oversize: 1'b0};
                    end
                    default:
                    begin
                        // Unknown marker: drop
                    end
                endcase
            end
            else
            begin
                acc_next = acc_upd;
                if (!lane_hit && byte_in.in_byte != '0)
                begin
                    ovf_next = 1'b1;
                end
                if (pos_reg != POS_MAX)
                begin
                    pos_next = pos_reg + 7'd1;
                end
                bytes_left_next = bytes_left_reg - 7'd1;
                // Last class byte: hand the value to the shifter
                if (bytes_left_reg == 7'd1)
                begin
                    emit_active_next = 1'b1;
                    emit_val_next    = acc_upd;
                    emit_flags_next  = '{pattern_end: 1'b0,
                                         oversize: ovf_next};
                end
            end
        end
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_class_reg <= 7'd0;
            skip_class_reg  <= 7'd3;
            flex_class_reg  <= 7'd4;
            bytes_left_reg  <= '0;
            pos_reg         <= '0;
            acc_reg         <= '0;
            ovf_reg         <= 1'b0;
            emit_active_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            bytes_left_reg  <= bytes_left_next;
            pos_reg         <= pos_next;
            acc_reg         <= acc_next;
            ovf_reg         <= ovf_next;
            emit_active_reg <= emit_active_next;
            out_valid_reg   <= out_valid_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_DELIMITER: delim_class_reg <= cfg.data;
                    CFG_SKIP:      skip_class_reg  <= cfg.data;
                    CFG_FLEX:      flex_class_reg  <= cfg.data;
                    default:
                    begin
                        // Index beyond the list: ignore
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        emit_val_reg   <= emit_val_next;
        emit_flags_reg <= emit_flags_next;
        out_byte_reg   <= out_byte_next;
        out_last_reg   <= out_last_next;
        out_flags_reg  <= out_flags_next;
    end

    // Continuation bit is set on every byte but the last
    a_cont_bit: assert property (@(posedge clk) disable iff (!rst_n)
        varint_out.valid |-> (varint_out.out_byte[7] == !varint_out.last))
        else $error("continuation bit disagrees with last");

    // No input transfer while the shifter still holds groups
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        emit_active_reg |-> !(byte_in.valid && byte_in.ready))
        else $error("input taken while emitting");

    // Delimiter results never carry the oversize flag
    a_delim_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (varint_out.valid && varint_out.pattern_end) |-> !varint_out.oversize)
        else $error("delimiter flagged oversize");

    // A stalled output byte holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (varint_out.valid && !varint_out.ready) |=>
            (varint_out.valid && $stable(varint_out.out_byte)))
        else $error("stalled output changed");

endmodule

// ----- tb/sv/lpvt_varint_checker.sv -----
`timescale 1ns / 100ps
// Watches the byte, varint and register channels of the transcoder.
// Predicts the varint bytes and compares them. Depends on lpvt_pkg and lpvt_channels.sv.
module lpvt_varint_checker
    import lpvt_pkg::*;
#(
    parameter int CLASS_BITS = 32
) (
    input  logic   clk,
    input  logic   rst_n,
    lpvt_byte_if   byte_mon,
    lpvt_varint_if varint_mon,
    lpvt_cfg_if    cfg_mon,
    output int     fail_count,
    output int     pending,
    output int     bytes_in,
    output int     bytes_out,
    output logic   in_header
);

    localparam int KEEP_BYTES = CLASS_BITS / 8;

    typedef struct packed {
        byte_t out_byte;
        logic  last;
        logic  pattern_end;
        logic  oversize;
    } varint_beat_t;

    varint_beat_t          varint_q[$];
    varint_beat_t          oldest;

    // Own copy of the class registers and the decoder state
    class_t                delim_cls;
    class_t                skip_cls;
    class_t                flex_cls;
    count_t                bytes_left;
    count_t                byte_pos;
    logic [CLASS_BITS-1:0] class_acc;
    logic                  overflow_seen;

    // Print one line for each of the first 32 mismatches and count every mismatch
    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        if (fail_count < 32)
            $display("%0t ns mismatch: %s got %0h expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    // Split a class into 7-bit groups, low group first, continuation bit on all but the last
    task automatic queue_varint(input logic [CLASS_BITS-1:0] value, input logic pend,
                                input logic big);
        logic [CLASS_BITS-1:0] rest;
        varint_beat_t          beat;
        rest = value;
        do
        begin
            beat.out_byte    = {1'b0, rest[6:0]};
            rest             = rest >> 7;
            beat.out_byte[7] = (rest != 0);
            beat.last        = (rest == 0);
            beat.pattern_end = pend;
            beat.oversize    = big;
            varint_q.insert(varint_q.size(), beat);
        end
        while (rest != 0);
    endtask

    // Advance the decoder by one stream byte
    task automatic predict_byte(input byte_t b);
        if (bytes_left == 0)
        begin
            if (b == HDR_DELIMITER)
                queue_varint(CLASS_BITS'(delim_cls), 1'b1, 1'b0);
            else if (b <= HDR_LEN_MAX)
            begin
                bytes_left    = b[6:0];
                byte_pos      = '0;
                class_acc     = '0;
                overflow_seen = 1'b0;
            end
            else if (b == HDR_SKIP)
                queue_varint(CLASS_BITS'(skip_cls), 1'b0, 1'b0);
            else if (b == HDR_FLEX)
                queue_varint(CLASS_BITS'(flex_cls), 1'b0, 1'b0);
            // any other marker is dropped
        end
        else
        begin
            // keep the low class bytes, note any nonzero byte beyond them
            if (byte_pos < KEEP_BYTES)
                class_acc = class_acc | (CLASS_BITS'(b) << (8 * byte_pos));
            else if (b != 0)
                overflow_seen = 1'b1;
            if (byte_pos < POS_MAX)
                byte_pos = byte_pos + 1'b1;
            bytes_left = bytes_left - 1'b1;
            if (bytes_left == 0)
                queue_varint(class_acc, 1'b0, overflow_seen);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            delim_cls     = 7'd0;
            skip_cls      = 7'd3;
            flex_cls      = 7'd4;
            bytes_left    = '0;
            byte_pos      = '0;
            class_acc     = '0;
            overflow_seen = 1'b0;
            fail_count    = 0;
            bytes_in      = 0;
            bytes_out     = 0;
            varint_q.delete();
        end
        else
        begin
            // Compare an output transfer with the oldest expectation
            if (varint_mon.valid && varint_mon.ready)
            begin
                bytes_out++;
                if (varint_q.size() == 0)
                    report("unexpected varint byte", varint_mon.out_byte, 8'h00);
                else
                begin
                    oldest = varint_q.pop_front();
                    if (varint_mon.out_byte !== oldest.out_byte)
                        report("out_byte", varint_mon.out_byte, oldest.out_byte);
                    if (varint_mon.last !== oldest.last)
                        report("last", 8'(varint_mon.last), 8'(oldest.last));
                    if (varint_mon.pattern_end !== oldest.pattern_end)
                        report("pattern_end", 8'(varint_mon.pattern_end),
                               8'(oldest.pattern_end));
                    if (varint_mon.oversize !== oldest.oversize)
                        report("oversize", 8'(varint_mon.oversize), 8'(oldest.oversize));
                end
            end

            // Track register writes; unknown indexes are dropped
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                case (cfg_mon.index)
                    CFG_DELIMITER: delim_cls = cfg_mon.data;
                    CFG_SKIP:      skip_cls  = cfg_mon.data;
                    CFG_FLEX:      flex_cls  = cfg_mon.data;
                    default:       ;
                endcase
            end

            // Predict from an input transfer
            if (byte_mon.valid && byte_mon.ready)
            begin
                bytes_in++;
                predict_byte(byte_mon.in_byte);
            end
        end
        pending   <= varint_q.size();
        in_header <= (bytes_left == 0);
    end

endmodule

// ----- tb/sv/length_prefixed_to_varint_transcoder_tb.sv -----
`timescale 1ns / 100ps
// Top of the transcoder testbench: clock, reset, stream and register stimulus, verdict.
// Depends on lpvt_pkg, lpvt_channels.sv, the transcoder RTL and lpvt_varint_checker.
module length_prefixed_to_varint_transcoder_tb;
    import lpvt_pkg::*;

    localparam cfg_idx_t CFG_UNUSED      = 2'd3;
    localparam int       QUIET_LIMIT     = 200;
    localparam int       ITEMS_PER_PHASE = 80;
    localparam int       N_DIRECTED      = 26;

    // Markers, short and long classes, a zero dropped byte and a nonzero one
    localparam byte_t DIRECTED [N_DIRECTED] = '{
        8'h00, 8'h80, 8'h81, 8'h82, 8'hFF,
        8'h01, 8'h00,
        8'h01, 8'hFF,
        8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'h05, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic steady;
    logic in_header;
    int   fail_count;
    int   pending;
    int   bytes_in;
    int   bytes_out;
    int   quiet_cycles = 0;
    int   items;
    int   reg_writes;
    int   settings;

    lpvt_byte_if   byte_in ();
    lpvt_varint_if varint_out ();
    lpvt_cfg_if    cfg ();

    length_prefixed_to_varint_transcoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .varint_out (varint_out),
        .cfg        (cfg)
    );

    lpvt_varint_checker varint_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_mon   (byte_in),
        .varint_mon (varint_out),
        .cfg_mon    (cfg),
        .fail_count (fail_count),
        .pending    (pending),
        .bytes_in   (bytes_in),
        .bytes_out  (bytes_out),
        .in_header  (in_header)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 5);
    endfunction

    // Offer one stream byte and hold it until transferred
    task automatic send_byte(input byte_t b);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            byte_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_in.valid   <= 1'b1;
        byte_in.in_byte <= b;
        do
            @(posedge clk);
        while (!byte_in.ready);
    endtask

    // Send a length header and its class bytes; bytes past the fourth are often zero
    task automatic send_class(input int len);
        byte_t b;
        send_byte(byte_t'(len));
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 3))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = byte_t'($urandom_range(0, 255));
            endcase
            if (i >= 4 && $urandom_range(0, 1) == 0)
                b = 8'h00;
            send_byte(b);
        end
        items += len + 1;
    endtask

    // Leave the register channel high between writes; the caller drops it
    task automatic write_reg(input cfg_idx_t idx, input class_t value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        reg_writes++;
    endtask

    task automatic load_classes(input class_t d, input class_t s, input class_t f);
        write_reg(CFG_DELIMITER, d);
        write_reg(CFG_SKIP, s);
        write_reg(CFG_FLEX, f);
        cfg.valid <= 1'b0;
        settings++;
    endtask

    // Return to header position, drain all expected bytes, then wait out the pipeline
    task automatic settle();
        byte_in.valid <= 1'b0;
        @(posedge clk);
        while (!in_header)
        begin
            send_byte(HDR_DELIMITER);
            byte_in.valid <= 1'b0;
            @(posedge clk);
        end
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly well-formed classes and markers, with some ignored and raw noise bytes
    task automatic random_phase(input int count, input logic calm);
        int target;
        int r;
        int len;
        target = items + count;
        if (calm)
            steady = 1'b1;
        while (items < target)
        begin
            if (!calm && $urandom_range(0, 39) == 0)
                steady = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    len = $urandom_range(1, 4);
                else if (r < 85)
                    len = $urandom_range(5, 8);
                else if (r < 97)
                    len = $urandom_range(9, 16);
                else if ($urandom_range(0, 1) == 0)
                    len = int'(HDR_LEN_MAX);
                else
                    len = $urandom_range(17, 126);
                send_class(len);
            end
            else if (r < 67)
            begin
                send_byte(HDR_DELIMITER);
                items++;
            end
            else if (r < 75)
            begin
                send_byte(HDR_SKIP);
                items++;
            end
            else if (r < 83)
            begin
                send_byte(HDR_FLEX);
                items++;
            end
            else if (r < 90)
                send_byte(byte_t'($urandom_range(130, 255)));
            else
            begin
                send_byte(byte_t'($urandom_range(0, 255)));
                items++;
            end
        end
        steady = 1'b0;
        settle();
    endtask

    // Receiver: stall a random number of cycles before each byte
    initial
    begin : varint_sink
        int stall;
        varint_out.ready <= 1'b0;
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                varint_out.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            varint_out.ready <= 1'b1;
            do
                @(posedge clk);
            while (!varint_out.valid);
        end
    end

    // Watchdog: end the run when no channel has moved for too long
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((byte_in.valid && byte_in.ready) || (varint_out.valid && varint_out.ready)
                 || (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
                $display("length_prefixed_to_varint_transcoder_tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        byte_in.valid   <= 1'b0;
        byte_in.in_byte <= 8'h00;
        cfg.valid       <= 1'b0;
        cfg.index       <= CFG_DELIMITER;
        cfg.data        <= 7'd0;
        steady     = 1'b0;
        items      = 0;
        reg_writes = 0;
        settings   = 1;
        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed bytes under the reset class values
        foreach (DIRECTED[i])
            send_byte(DIRECTED[i]);
        items += N_DIRECTED - 2;
        settle();
        random_phase(ITEMS_PER_PHASE, 1'b0);

        // Top and bottom of the class range, then random settings
        load_classes(7'h7F, 7'h7F, 7'h7F);
        random_phase(ITEMS_PER_PHASE, 1'b0);
        load_classes(7'h00, 7'h00, 7'h00);
        random_phase(ITEMS_PER_PHASE, 1'b1);
        write_reg(CFG_UNUSED, class_t'($urandom_range(0, 127)));
        load_classes(class_t'($urandom_range(0, 127)), class_t'($urandom_range(0, 127)),
                     class_t'($urandom_range(0, 127)));
        random_phase(ITEMS_PER_PHASE, 1'b0);
        load_classes(7'h7F, 7'h00, class_t'($urandom_range(0, 127)));
        random_phase(ITEMS_PER_PHASE, 1'b0);
        load_classes(class_t'($urandom_range(0, 127)), class_t'($urandom_range(0, 127)),
                     class_t'($urandom_range(0, 127)));
        random_phase(ITEMS_PER_PHASE, 1'b0);

        repeat (20) @(posedge clk);
        $display("covered %0d stream bytes (%0d counted items) and %0d varint bytes",
                 bytes_in, items, bytes_out);
        $display("with %0d register writes over %0d class settings, %0d mismatches",
                 reg_writes, settings, fail_count);
        if (fail_count == 0)
            $display("length_prefixed_to_varint_transcoder_tb: PASS");
        else
            $display("length_prefixed_to_varint_transcoder_tb: FAIL");
        $finish;
    end

endmodule
